// File: hw/rtl/srss_pkg.sv
// shared types and constants for the selective-repeat sender scoreboard
`timescale 1ns / 1ps

package srss_pkg;

   localparam int SEQ_W      = 5;
   localparam int ACT_W      = 2;
   localparam int ACK_SEQ_W  = 6;
   localparam int ACK_CNT_W  = 6;
   localparam int SENT_CNT_W = 16;
   localparam int TIME_W     = 32;
   localparam int TOTAL_W    = 6;
   localparam int CMP_W      = 7;
   localparam int STAT_W     = 2;
   localparam int ENT_W      = STAT_W + TIME_W;
   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 3;

   // item actions
   localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ACK  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_POLL = 2'd2;

   // per-packet status
   localparam logic [STAT_W-1:0] ENT_NOT_SENT = 2'd0;
   localparam logic [STAT_W-1:0] ENT_SENT     = 2'd1;
   localparam logic [STAT_W-1:0] ENT_ACKED    = 2'd2;

   // ack status codes
   localparam logic [1:0] ACK_NEW   = 2'd0;
   localparam logic [1:0] ACK_DUP   = 2'd1;
   localparam logic [1:0] ACK_RANGE = 2'd2;
   localparam logic [1:0] ACK_NONE  = 2'd3;

   localparam logic [ACK_CNT_W-1:0]  ACK_CNT_MAX  = '1;
   localparam logic [SENT_CNT_W-1:0] SENT_CNT_MAX = '1;
   localparam logic [TIME_W-1:0]     TIMEOUT_RESET = 32'd1000;

   // register index taken from the address
   localparam logic REG_TOTAL   = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE    = 4'd0,
      OP_TICK    = 4'd1,
      OP_NOP     = 4'd2,
      OP_ACK_RD  = 4'd3,
      OP_ACK_UPD = 4'd4,
      OP_POLL_RD = 4'd5,
      OP_SLIDE   = 4'd6,
      OP_SCAN    = 4'd7,
      OP_FINISH  = 4'd8
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic slide_adv;
      logic scan_end;
   } stat_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total_packets;
      logic [TIME_W-1:0]  timeout_ticks;
   } cfg_type;

endpackage

// File: hw/rtl/srss_csr.sv
// configuration registers behind the apb-style port
`timescale 1ns / 1ps

module srss_csr import srss_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TIME_W-1:0]  timeout_ff, timeout_in;
   logic               wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      total_in   = total_ff;
      timeout_in = timeout_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_TOTAL:   total_in   = pwdata[TOTAL_W-1:0];
            REG_TIMEOUT: timeout_in = pwdata[TIME_W-1:0];
            default:     total_in   = total_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_TOTAL:   prdata = DATA_W'(total_ff);
         REG_TIMEOUT: prdata = DATA_W'(timeout_ff);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         total_ff   <= total_in;
         timeout_ff <= timeout_in;
      end
   end

   assign cfg.total_packets = total_ff;
   assign cfg.timeout_ticks = timeout_ff;

endmodule

// File: hw/rtl/srss_ctrl.sv
// sequencing state machine for ack, tick and poll items
`timescale 1ns / 1ps

module srss_ctrl import srss_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [ACT_W-1:0] action,
   input  stat_type         stat,
   output logic             busy,
   output cmd_type          cmd
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_ACK_CHK = 5'b00010,
      S_SLIDE   = 5'b00100,
      S_SCAN    = 5'b01000,
      S_FINISH  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (action)
                  ACT_TICK: cmd.op = OP_TICK;
                  ACT_ACK: begin
                     cmd.op   = OP_ACK_RD;
                     state_in = S_ACK_CHK;
                  end
                  ACT_POLL: begin
                     cmd.op   = OP_POLL_RD;
                     state_in = S_SLIDE;
                  end
                  default: cmd.op = OP_NOP;
               endcase
            end
         end
         S_ACK_CHK: begin
            cmd.op   = OP_ACK_UPD;
            state_in = S_IDLE;
         end
         S_SLIDE: begin
            cmd.op = OP_SLIDE;
            if (!stat.slide_adv) state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (stat.scan_end) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.op   = OP_FINISH;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: hw/rtl/srss_dp.sv
// packet table, window and counters, result register
`timescale 1ns / 1ps

module srss_dp import srss_pkg::*; #(
   parameter int MAX_PACKETS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  cfg_type               cfg,
   input  logic [ACK_SEQ_W-1:0]  ack_seq,
   output stat_type              stat,
   output logic                  rsp_strobe,
   output logic                  rsp_send_valid,
   output logic [SEQ_W-1:0]      rsp_send_seq,
   output logic                  rsp_is_resend,
   output logic                  rsp_last,
   output logic [1:0]            rsp_ack_status,
   output logic                  rsp_all_done,
   output logic [ACK_CNT_W-1:0]  rsp_acked_count,
   output logic [SENT_CNT_W-1:0] rsp_sent_count
);

   localparam int CNT_W = $clog2(MAX_PACKETS + 1);
   localparam int IDX_W = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;

   // table memory: {status, send time}; valid bits stand for the reset value
   logic [ENT_W-1:0]       entry_mem [MAX_PACKETS];
   logic [MAX_PACKETS-1:0] valid_ff, valid_in;
   logic [ENT_W-1:0]       rd_data_ff;
   logic                   rd_valid_ff;
   logic                   rd_en, wr_en;
   logic [IDX_W-1:0]       rd_addr, wr_addr;
   logic [ENT_W-1:0]       wr_data;

   logic [CNT_W-1:0]      base_ff, base_in, base_nxt;
   logic [CNT_W-1:0]      idx_ff, idx_in, idx_nxt;
   logic [TIME_W-1:0]     time_ff, time_in;
   logic [ACK_CNT_W-1:0]  acks_ff, acks_in;
   logic [SENT_CNT_W-1:0] sends_ff, sends_in, sends_inc;
   logic [ACK_SEQ_W-1:0]  seq_ff, seq_in;

   // send waiting for the next one, so that the final send can carry last
   logic                  pend_valid_ff, pend_valid_in;
   logic [SEQ_W-1:0]      pend_seq_ff, pend_seq_in;
   logic                  pend_resend_ff, pend_resend_in;
   logic [SENT_CNT_W-1:0] pend_sent_ff, pend_sent_in;

   logic                  strobe_ff, strobe_in;
   logic                  sv_ff, sv_in;
   logic [SEQ_W-1:0]      sseq_ff, sseq_in;
   logic                  resend_ff, resend_in;
   logic                  last_ff, last_in;
   logic [1:0]            astat_ff, astat_in;
   logic                  done_ff, done_in;
   logic [ACK_CNT_W-1:0]  acnt_ff, acnt_in;
   logic [SENT_CNT_W-1:0] scnt_ff, scnt_in;

   logic [CNT_W-1:0]  eff_total;
   logic [STAT_W-1:0] ent_status;
   logic [TIME_W-1:0] ent_time;
   logic [TIME_W-1:0] elapsed;
   logic              timed_out;
   logic              do_send;
   logic              seq_out_range;

   assign eff_total = ({1'b0, cfg.total_packets} > CMP_W'(MAX_PACKETS))
                      ? CNT_W'(MAX_PACKETS) : CNT_W'(cfg.total_packets);

   assign ent_status = rd_valid_ff ? rd_data_ff[ENT_W-1:TIME_W] : ENT_NOT_SENT;
   assign ent_time   = rd_data_ff[TIME_W-1:0];
   assign elapsed    = time_ff - ent_time;
   assign timed_out  = (ent_status == ENT_SENT) && (elapsed > cfg.timeout_ticks);
   assign do_send    = (ent_status == ENT_NOT_SENT) || timed_out;

   assign base_nxt  = base_ff + CNT_W'(1);
   assign idx_nxt   = idx_ff + CNT_W'(1);
   assign sends_inc = (sends_ff == SENT_CNT_MAX) ? sends_ff : sends_ff + SENT_CNT_W'(1);
   assign seq_out_range = ({1'b0, seq_ff} >= CMP_W'(eff_total));

   assign stat.slide_adv = (base_ff < eff_total) && (ent_status == ENT_ACKED);
   assign stat.scan_end  = !(idx_ff < eff_total);

   always_comb begin
      base_in        = base_ff;
      idx_in         = idx_ff;
      time_in        = time_ff;
      acks_in        = acks_ff;
      sends_in       = sends_ff;
      seq_in         = seq_ff;
      valid_in       = valid_ff;
      pend_valid_in  = pend_valid_ff;
      pend_seq_in    = pend_seq_ff;
      pend_resend_in = pend_resend_ff;
      pend_sent_in   = pend_sent_ff;
      rd_en          = 1'b0;
      rd_addr        = idx_nxt[IDX_W-1:0];
      wr_en          = 1'b0;
      wr_addr        = idx_ff[IDX_W-1:0];
      wr_data        = {ENT_SENT, time_ff};
      strobe_in      = 1'b0;
      sv_in          = 1'b0;
      sseq_in        = '0;
      resend_in      = 1'b0;
      last_in        = 1'b1;
      astat_in       = ACK_NONE;
      done_in        = !(base_ff < eff_total);
      acnt_in        = acks_ff;
      scnt_in        = sends_ff;

      case (cmd.op)
         OP_TICK: begin
            time_in   = time_ff + TIME_W'(1);
            strobe_in = 1'b1;
         end
         OP_NOP: begin
            strobe_in = 1'b1;
         end
         OP_ACK_RD: begin
            seq_in  = ack_seq;
            rd_en   = 1'b1;
            rd_addr = ack_seq[IDX_W-1:0];
         end
         OP_ACK_UPD: begin
            strobe_in = 1'b1;
            if (seq_out_range) begin
               astat_in = ACK_RANGE;
            end else if (ent_status == ENT_ACKED) begin
               astat_in = ACK_DUP;
            end else begin
               // a never-sent packet is marked acked too
               wr_en    = 1'b1;
               wr_addr  = seq_ff[IDX_W-1:0];
               wr_data  = {ENT_ACKED, ent_time};
               acks_in  = (acks_ff == ACK_CNT_MAX) ? acks_ff : acks_ff + ACK_CNT_W'(1);
               acnt_in  = acks_in;
               astat_in = ACK_NEW;
            end
         end
         OP_POLL_RD: begin
            rd_en         = 1'b1;
            rd_addr       = base_ff[IDX_W-1:0];
            pend_valid_in = 1'b0;
         end
         OP_SLIDE: begin
            if (stat.slide_adv) begin
               base_in = base_nxt;
               rd_en   = 1'b1;
               rd_addr = base_nxt[IDX_W-1:0];
            end else begin
               // read data already holds the entry at the base
               idx_in = base_ff;
            end
         end
         OP_SCAN: begin
            if (!stat.scan_end) begin
               idx_in = idx_nxt;
               rd_en  = 1'b1;
               if (do_send) begin
                  wr_en    = 1'b1;
                  sends_in = sends_inc;
                  if (pend_valid_ff) begin
                     strobe_in = 1'b1;
                     sv_in     = 1'b1;
                     sseq_in   = pend_seq_ff;
                     resend_in = pend_resend_ff;
                     last_in   = 1'b0;
                     scnt_in   = pend_sent_ff;
                  end
                  pend_valid_in  = 1'b1;
                  pend_seq_in    = SEQ_W'(idx_ff);
                  pend_resend_in = timed_out;
                  pend_sent_in   = sends_inc;
               end
            end
         end
         OP_FINISH: begin
            strobe_in     = 1'b1;
            pend_valid_in = 1'b0;
            if (pend_valid_ff) begin
               sv_in     = 1'b1;
               sseq_in   = pend_seq_ff;
               resend_in = pend_resend_ff;
               scnt_in   = pend_sent_ff;
            end
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase

      if (wr_en) valid_in[wr_addr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         base_ff       <= '0;
         time_ff       <= '0;
         acks_ff       <= '0;
         sends_ff      <= '0;
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         if (rd_en) rd_valid_ff <= valid_ff[rd_addr];
         base_ff       <= base_in;
         time_ff       <= time_in;
         acks_ff       <= acks_in;
         sends_ff      <= sends_in;
         pend_valid_ff <= pend_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      seq_ff         <= seq_in;
      pend_seq_ff    <= pend_seq_in;
      pend_resend_ff <= pend_resend_in;
      pend_sent_ff   <= pend_sent_in;
      sv_ff          <= sv_in;
      sseq_ff        <= sseq_in;
      resend_ff      <= resend_in;
      last_ff        <= last_in;
      astat_ff       <= astat_in;
      done_ff        <= done_in;
      acnt_ff        <= acnt_in;
      scnt_ff        <= scnt_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_send_valid  = sv_ff;
   assign rsp_send_seq    = sseq_ff;
   assign rsp_is_resend   = resend_ff;
   assign rsp_last        = last_ff;
   assign rsp_ack_status  = astat_ff;
   assign rsp_all_done    = done_ff;
   assign rsp_acked_count = acnt_ff;
   assign rsp_sent_count  = scnt_ff;

endmodule

// File: hw/rtl/selective_repeat_sender_scoreboard.sv
// selective-repeat arq sender scoreboard, top level
// usage: an item (req_action, req_ack_seq) is taken when start is high and
// busy is low. a tick advances the time counter, an ack marks a packet acked
// and reports new, duplicate or out of range, a poll orders sends and
// timeout resends from the window base up to the packet total.
// every result appears on the rsp_ ports for one cycle with rsp_strobe high;
// rsp_last marks the final result of an item. the receiver cannot stall, so
// results are never held back.
// order of work: tick and unused actions give a registered result and busy
// never rises, so they can follow one per cycle; an ack goes through a table
// read and then an update before its result and the next transfer.
// a poll reads the entry at the window base, slides the base past acked
// entries, then scans from the slid base up to the packet total (the scan ends
// at once when the base has reached the total), one table entry per cycle
// through the table memory, then closes; its results pass through the result
// register. sends show up while the scan runs, each one held until the next.
// the configuration port (total_packets at 0, timeout_ticks at 4) is to be written
// by the user only while the block is idle; the block does not enforce this. pready is always high.
// reset: all packets read as not sent, window base, time and counts are zero,
// timeout_ticks is 1000 and total_packets is 0.
`timescale 1ns / 1ps

module selective_repeat_sender_scoreboard import srss_pkg::*; #(
   parameter int MAX_PACKETS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ACT_W-1:0]      req_action,
   input  logic [ACK_SEQ_W-1:0]  req_ack_seq,
   output logic                  rsp_strobe,
   output logic                  rsp_send_valid,
   output logic [SEQ_W-1:0]      rsp_send_seq,
   output logic                  rsp_is_resend,
   output logic                  rsp_last,
   output logic [1:0]            rsp_ack_status,
   output logic                  rsp_all_done,
   output logic [ACK_CNT_W-1:0]  rsp_acked_count,
   output logic [SENT_CNT_W-1:0] rsp_sent_count,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_W-1:0]     paddr,
   input  logic [DATA_W-1:0]     pwdata,
   output logic [DATA_W-1:0]     prdata,
   output logic                  pready
);

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   srss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   srss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_action),
      .stat   (stat),
      .busy   (busy),
      .cmd    (cmd)
   );

   srss_dp #(
      .MAX_PACKETS (MAX_PACKETS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .ack_seq         (req_ack_seq),
      .stat            (stat),
      .rsp_strobe      (rsp_strobe),
      .rsp_send_valid  (rsp_send_valid),
      .rsp_send_seq    (rsp_send_seq),
      .rsp_is_resend   (rsp_is_resend),
      .rsp_last        (rsp_last),
      .rsp_ack_status  (rsp_ack_status),
      .rsp_all_done    (rsp_all_done),
      .rsp_acked_count (rsp_acked_count),
      .rsp_sent_count  (rsp_sent_count)
   );

endmodule
